// ===== hw/rtl/grnb_pkg.sv =====
// Package for the glyph row nibble blitter.
// Holds payload structs, the queued row descriptor and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package grnb_pkg;

   localparam int GLYPH_SIZE  = 12;
   localparam int PIX_W       = 2;
   localparam int NIB_W       = 4;
   localparam int BYTE_W      = 8;
   localparam int ROW_BITS    = GLYPH_SIZE * PIX_W;
   localparam int HALF_BYTES  = GLYPH_SIZE / 2;
   localparam int BYTES_MAX   = HALF_BYTES + 1;
   localparam int BYTE_IDX_W  = $clog2(BYTES_MAX);
   localparam int ADDR_W      = 20;
   localparam int X_W         = 10;
   localparam int Y_W         = 9;
   localparam int ROW_W       = 4;
   localparam int LW_W        = 10;
   localparam int COLOR_W     = 2;
   localparam int STEP_W      = 4;
   localparam int MARK_BYTES  = 2;

   localparam logic [LW_W-1:0]    LINE_WIDTH_RESET = 10'd256;
   localparam logic [PIX_W-1:0]   MARK_PIXEL       = 2'b11;
   localparam logic [ADDR_W-1:0]  MARK_RAISE_HIGH  = 20'd4;
   localparam logic [ADDR_W-1:0]  MARK_RAISE_LOW   = 20'd2;

   localparam logic [1:0] CSR_LINE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_COLOR_CODE  = 2'd1;
   localparam logic [1:0] CSR_MARK_ENABLE = 2'd2;
   localparam logic [1:0] CSR_RUBY_RAISE  = 2'd3;

   localparam logic [1:0] MASK_LOW  = 2'b01;
   localparam logic [1:0] MASK_HIGH = 2'b10;
   localparam logic [1:0] MASK_BOTH = 2'b11;

   typedef struct packed {
      logic [X_W-1:0]      pos_x;
      logic [Y_W-1:0]      pos_y;
      logic [ROW_W-1:0]    row;
      logic [ROW_BITS-1:0] row_pixels;
      logic                blank;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] byte_addr;
      logic [BYTE_W-1:0] byte_data;
      logic [1:0]        nibble_mask;
      logic              combine_or;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic                              mark;
      logic                              odd;
      logic                              combine_or;
      logic [COLOR_W-1:0]                color;
      logic [LW_W-1:0]                   line_width;
      logic [ADDR_W-1:0]                 mark_addr;
      logic [ADDR_W-1:0]                 base_addr;
      logic [BYTES_MAX-1:0][BYTE_W-1:0]  bytes;
   } desc_type;

endpackage

// ===== hw/rtl/grnb_front.sv =====
// Front end: configuration registers, row accept and descriptor build.
// Computes row and marker addresses and the byte images. Uses grnb_pkg.
`timescale 1ns / 1ps

module grnb_front
   import grnb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [LW_W-1:0]   csr_wdata,
   input  logic              req_valid,
   input  req_type           req_data,
   input  logic              queue_full,
   output logic              req_stall,
   output logic              push,
   output desc_type          push_desc
);

   logic [LW_W-1:0]    line_width_ff;
   logic [COLOR_W-1:0] color_code_ff;
   logic               mark_enable_ff;
   logic               ruby_raise_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= LINE_WIDTH_RESET;
         color_code_ff  <= '0;
         mark_enable_ff <= 1'b0;
         ruby_raise_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:  line_width_ff  <= csr_wdata;
            CSR_COLOR_CODE:  color_code_ff  <= csr_wdata[COLOR_W-1:0];
            CSR_MARK_ENABLE: mark_enable_ff <= csr_wdata[0];
            CSR_RUBY_RAISE:  ruby_raise_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   logic [ROW_BITS-1:0]              bits;
   logic [GLYPH_SIZE-1:0][NIB_W-1:0] nib;
   logic [LW_W-1:0]                  row_line;
   logic [ADDR_W-1:0]                row_prod;
   logic [X_W:0]                     col_sum;
   logic [ADDR_W-1:0]                mark_line;
   logic [ADDR_W-1:0]                mark_prod;

   always_comb begin
      bits = req_data.blank ? '0 : req_data.row_pixels;
      for (int j = 0; j < GLYPH_SIZE; j++) begin
         nib[j] = {color_code_ff, bits[ROW_BITS-1-PIX_W*j -: PIX_W]};
      end

      row_line  = LW_W'(req_data.pos_y) + LW_W'(1) + LW_W'(req_data.row);
      row_prod  = ADDR_W'(row_line) * ADDR_W'(line_width_ff);
      col_sum   = (X_W+1)'(req_data.pos_x) + (X_W+1)'(5);
      mark_line = ADDR_W'(req_data.pos_y)
                  - (ruby_raise_ff ? MARK_RAISE_HIGH : MARK_RAISE_LOW);
      mark_prod = mark_line * ADDR_W'(line_width_ff);

      push_desc            = '0;
      push_desc.mark       = (req_data.row == '0) && mark_enable_ff;
      push_desc.odd        = req_data.pos_x[0];
      push_desc.combine_or = req_data.pos_x[0] && !req_data.blank;
      push_desc.color      = color_code_ff;
      push_desc.line_width = line_width_ff;
      push_desc.mark_addr  = ADDR_W'(col_sum[X_W:1]) + mark_prod;
      push_desc.base_addr  = ADDR_W'(req_data.pos_x[X_W-1:1]) + row_prod;

      if (req_data.pos_x[0]) begin
         push_desc.bytes[0] = {nib[0], NIB_W'(0)};
         for (int k = 1; k < HALF_BYTES; k++) begin
            push_desc.bytes[k] = {nib[2*k], nib[2*k-1]};
         end
         push_desc.bytes[HALF_BYTES] = {NIB_W'(0), nib[GLYPH_SIZE-1]};
      end else begin
         for (int k = 0; k < HALF_BYTES; k++) begin
            push_desc.bytes[k] = {nib[2*k+1], nib[2*k]};
         end
      end
   end

endmodule

// ===== hw/rtl/grnb_queue.sv =====
// Short descriptor queue between front and back.
// Register-based FIFO with head read-out. Uses grnb_pkg.
`timescale 1ns / 1ps

module grnb_queue
   import grnb_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     full,
   output logic     head_valid,
   output desc_type head_desc
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type           mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         priority if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/grnb_back.sv =====
// Back end: walks the head descriptor and emits one byte write per cycle while the output is not stalled.
// Marker writes first, then the row bytes, into an output register. Uses grnb_pkg.
`timescale 1ns / 1ps

module grnb_back
   import grnb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     head_valid,
   input  desc_type head_desc,
   output logic     pop,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [STEP_W-1:0]     step_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   logic [STEP_W-1:0]     mark_cnt;
   logic [STEP_W-1:0]     total;
   logic [STEP_W-1:0]     k_full;
   logic [BYTE_IDX_W-1:0] k;
   logic                  in_mark;
   logic                  advance;
   rsp_type               next_rsp;

   always_comb begin
      mark_cnt = head_desc.mark ? STEP_W'(MARK_BYTES) : '0;
      total    = mark_cnt + (head_desc.odd ? STEP_W'(BYTES_MAX) : STEP_W'(HALF_BYTES));
      in_mark  = head_desc.mark && (step_ff < STEP_W'(MARK_BYTES));
      k_full   = step_ff - mark_cnt;
      k        = k_full[BYTE_IDX_W-1:0];
      advance  = head_valid && (!rsp_valid_ff || !rsp_stall);

      next_rsp      = '0;
      next_rsp.last = (step_ff == total - 1'b1);
      if (in_mark) begin
         next_rsp.byte_addr   = step_ff[0] ? head_desc.mark_addr
                                : head_desc.mark_addr - ADDR_W'(head_desc.line_width);
         next_rsp.byte_data   = {head_desc.color, MARK_PIXEL, head_desc.color, MARK_PIXEL};
         next_rsp.nibble_mask = MASK_BOTH;
         next_rsp.combine_or  = 1'b1;
      end else begin
         next_rsp.byte_addr  = head_desc.base_addr + ADDR_W'(k);
         next_rsp.byte_data  = head_desc.bytes[k];
         next_rsp.combine_or = head_desc.combine_or;
         priority if (!head_desc.odd) begin
            next_rsp.nibble_mask = MASK_BOTH;
         end else if (k == '0) begin
            next_rsp.nibble_mask = MASK_HIGH;
         end else if (k == BYTE_IDX_W'(HALF_BYTES)) begin
            next_rsp.nibble_mask = MASK_LOW;
         end else begin
            next_rsp.nibble_mask = MASK_BOTH;
         end
      end
   end

   assign pop       = advance && next_rsp.last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (advance) begin
            rsp_valid_ff <= 1'b1;
            step_ff      <= next_rsp.last ? '0 : step_ff + 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= next_rsp;
      end
   end

endmodule

// ===== hw/rtl/glyph_row_nibble_blit.sv =====
// Glyph row blitter for a 4-bit-per-pixel framebuffer, one byte write per cycle while the output is not stalled.
// The first write of a row passes through the queue and then the output register.
// Each row gives 6 or 7 row bytes, plus 2 marker bytes on row 0 with marks on;
// further rows wait in the queue while the back end writes the current one.
// Reset: synchronous, active high; clears queue, sequencer and output valid,
// and loads register defaults.
`timescale 1ns / 1ps

module glyph_row_nibble_blit
   import grnb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [1:0]      csr_index,
   input  logic [LW_W-1:0] csr_wdata,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_type         req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data
);

   logic     queue_full;
   logic     push;
   desc_type push_desc;
   logic     pop;
   logic     head_valid;
   desc_type head_desc;

   grnb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_desc  (push_desc)
   );

   grnb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   grnb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hw/rtl/grnb_checker.sv =====
// Port-level checks for glyph_row_nibble_blit, bound to the top level.
// Uses grnb_pkg.
`timescale 1ns / 1ps

module grnb_checker
   import grnb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_type         rsp_data
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transaction changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.nibble_mask != 2'b00)
      else $error("write with empty nibble mask");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("gap inside a row burst");

   a_partial_mask_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last && rsp_data.nibble_mask == MASK_LOW
      |=> 1'b0)
      else $error("low-only write not last of its row");

endmodule

bind glyph_row_nibble_blit grnb_checker u_grnb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_top.sv =====
// Testbench for glyph_row_nibble_blit: glyph rows in, byte writes out, checked in order.
// Uses grnb_pkg for the payload structs and register indexes; stands alone otherwise.
`timescale 1ns / 1ps

module tb_top;
   import grnb_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 64;
   localparam int ROWS_PER_CFG  = 39;

   typedef enum logic [1:0] {STEP_ROW, STEP_FIXED, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type kind;
      logic [1:0]    csr_idx;
      logic [9:0]    csr_val;
      req_type       rq;
      logic [19:0]   addr0;
      logic [7:0]    data;
   } dir_step_type;

   typedef struct packed {
      logic         preset;
      logic [19:0]  addr0;
      logic [7:0]   data;
   } fixed_row_type;

   localparam req_type NO_ROW = '0;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [1:0]       csr_index = CSR_LINE_WIDTH;
   logic [LW_W-1:0]  csr_wdata = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;

   logic [9:0]       cfg_line_width = LINE_WIDTH_RESET;
   logic [1:0]       cfg_color = '0;
   logic             cfg_mark = 1'b0;
   logic             cfg_raise = 1'b0;

   rsp_type          pending_writes [$];
   fixed_row_type    fixed_rows [$];
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;
   logic             hold_armed = 1'b0;
   int               hold_count = 0;

   dir_step_type directed_steps [0:30] = '{
      '{STEP_FIXED, CSR_LINE_WIDTH, 10'd0, {10'd0, 9'd0, 4'd0, 24'h000000, 1'b1},
        20'd256, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd1023, 9'd511, 4'd11, 24'hFFFFFF, 1'b0},
        20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd2, 9'd5, 4'd3, 24'hE4E4E4, 1'b0}, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd1, 9'd0, 4'd0, 24'h123456, 1'b1}, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd1, 9'd9, 4'd2, 24'h000000, 1'b0}, 20'd0, 8'h00},
      '{STEP_CSR, CSR_COLOR_CODE, 10'd3, NO_ROW, 20'd0, 8'h00},
      '{STEP_FIXED, CSR_LINE_WIDTH, 10'd0, {10'd10, 9'd0, 4'd1, 24'hFFFFFF, 1'b1},
        20'd517, 8'hCC},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd0, 9'd100, 4'd15, 24'h000000, 1'b0},
        20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd513, 9'd7, 4'd4, 24'hA5A5A5, 1'b0},
        20'd0, 8'h00},
      '{STEP_CSR, CSR_LINE_WIDTH, 10'd512, NO_ROW, 20'd0, 8'h00},
      '{STEP_CSR, CSR_MARK_ENABLE, 10'd1, NO_ROW, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd1023, 9'd0, 4'd0, 24'h3C3C3C, 1'b0},
        20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd0, 9'd511, 4'd0, 24'h000000, 1'b1},
        20'd0, 8'h00},
      '{STEP_CSR, CSR_RUBY_RAISE, 10'd1, NO_ROW, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd7, 9'd3, 4'd0, 24'h9F06C1, 1'b0}, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd6, 9'd1, 4'd0, 24'h000000, 1'b1}, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd8, 9'd20, 4'd12, 24'hFFFFFF, 1'b0},
        20'd0, 8'h00},
      '{STEP_CSR, CSR_LINE_WIDTH, 10'd1, NO_ROW, 20'd0, 8'h00},
      '{STEP_CSR, CSR_COLOR_CODE, 10'd1, NO_ROW, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd0, 9'd0, 4'd0, 24'h5A5A5A, 1'b0}, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd1022, 9'd510, 4'd11, 24'h0F0F0F, 1'b0},
        20'd0, 8'h00},
      '{STEP_CSR, CSR_LINE_WIDTH, 10'd0, NO_ROW, 20'd0, 8'h00},
      '{STEP_FIXED, CSR_LINE_WIDTH, 10'd0, {10'd20, 9'd50, 4'd5, 24'h000000, 1'b1},
        20'd10, 8'h44},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd3, 9'd2, 4'd0, 24'h777777, 1'b0}, 20'd0, 8'h00},
      '{STEP_CSR, CSR_LINE_WIDTH, 10'd1023, NO_ROW, 20'd0, 8'h00},
      '{STEP_CSR, CSR_COLOR_CODE, 10'd2, NO_ROW, 20'd0, 8'h00},
      '{STEP_CSR, CSR_MARK_ENABLE, 10'd0, NO_ROW, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd511, 9'd300, 4'd7, 24'h5A5A5A, 1'b0},
        20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd0, 9'd0, 4'd15, 24'h000000, 1'b1}, 20'd0, 8'h00},
      '{STEP_ROW, CSR_LINE_WIDTH, 10'd0, {10'd1, 9'd511, 4'd0, 24'hFFFFFF, 1'b1},
        20'd0, 8'h00},
      '{STEP_CSR, CSR_RUBY_RAISE, 10'd0, NO_ROW, 20'd0, 8'h00}
   };

   glyph_row_nibble_blit dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void push_write(logic [19:0] addr, logic [7:0] data, logic [1:0] mask,
                                      logic orc, logic fin);
      rsp_type w;
      w.byte_addr   = addr;
      w.byte_data   = data;
      w.nibble_mask = mask;
      w.combine_or  = orc;
      w.last        = fin;
      pending_writes.push_back(w);
   endfunction

   function automatic void blit_row_writes(req_type r);
      logic [3:0]  nib [12];
      logic [7:0]  fill;
      logic [19:0] lw;
      logic [19:0] mline;
      logic [19:0] col;
      logic [19:0] base;
      lw   = 20'(cfg_line_width);
      fill = {cfg_color, 2'b00, cfg_color, 2'b00};
      for (int j = 0; j < 12; j++)
         nib[j] = {cfg_color, r.row_pixels[23 - 2*j -: 2]};
      if (r.row == 0 && cfg_mark) begin
         mline = 20'(r.pos_y) - (cfg_raise ? MARK_RAISE_HIGH : MARK_RAISE_LOW);
         col   = (20'(r.pos_x) + 20'd5) >> 1;
         push_write(col + (mline - 20'd1) * lw, fill | 8'h33, MASK_BOTH, 1'b1, 1'b0);
         push_write(col + mline * lw, fill | 8'h33, MASK_BOTH, 1'b1, 1'b0);
      end
      base = 20'(r.pos_x >> 1) + (20'(r.pos_y) + 20'(r.row) + 20'd1) * lw;
      if (!r.pos_x[0]) begin
         for (int k = 0; k < 6; k++)
            push_write(base + 20'(k), r.blank ? fill : {nib[2*k+1], nib[2*k]},
                       MASK_BOTH, 1'b0, k == 5);
      end else if (r.blank) begin
         push_write(base, fill & 8'hF0, MASK_HIGH, 1'b0, 1'b0);
         for (int k = 1; k < 6; k++)
            push_write(base + 20'(k), fill, MASK_BOTH, 1'b0, 1'b0);
         push_write(base + 20'd6, fill & 8'h0F, MASK_LOW, 1'b0, 1'b1);
      end else begin
         push_write(base, {nib[0], 4'h0}, MASK_HIGH, 1'b1, 1'b0);
         for (int k = 1; k < 6; k++)
            push_write(base + 20'(k), {nib[2*k], nib[2*k-1]}, MASK_BOTH, 1'b1, 1'b0);
         push_write(base + 20'd6, {4'h0, nib[11]}, MASK_LOW, 1'b1, 1'b1);
      end
   endfunction

   function automatic req_type random_row();
      req_type r;
      int      pick;
      r.pos_x = 10'($urandom_range(0, 1023));
      r.pos_y = 9'($urandom_range(0, 511));
      pick    = $urandom_range(0, 9);
      if (pick < 4)
         r.row = '0;
      else if (pick < 9)
         r.row = 4'($urandom_range(1, 11));
      else
         r.row = 4'($urandom_range(12, 15));
      r.row_pixels = 24'($urandom);
      r.blank      = ($urandom_range(0, 3) == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [9:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LINE_WIDTH:  cfg_line_width = val;
         CSR_COLOR_CODE:  cfg_color = val[1:0];
         CSR_MARK_ENABLE: cfg_mark = val[0];
         CSR_RUBY_RAISE:  cfg_raise = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0 || fixed_rows.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_config();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         csr_write(CSR_LINE_WIDTH, 10'd0);
      else if (pick == 1)
         csr_write(CSR_LINE_WIDTH, 10'($urandom_range(513, 1023)));
      else
         csr_write(CSR_LINE_WIDTH, 10'($urandom_range(1, 512)));
      csr_write(CSR_COLOR_CODE, 10'($urandom_range(0, 3)));
      csr_write(CSR_MARK_ENABLE, 10'($urandom_range(0, 9) < 7));
      csr_write(CSR_RUBY_RAISE, 10'($urandom_range(0, 1)));
   endtask

   task automatic send_row(input req_type r, input logic preset, input logic [19:0] addr0,
                           input logic [7:0] data);
      fixed_row_type fr;
      fr.preset = preset;
      fr.addr0  = addr0;
      fr.data   = data;
      fixed_rows.push_back(fr);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // hold off once for a long stretch when armed, else stall at random
   always @(posedge clock) begin
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type       want;
      fixed_row_type fr;
      logic          moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            fr = fixed_rows.pop_front();
            if (fr.preset) begin
               for (int k = 0; k < 6; k++)
                  push_write(fr.addr0 + 20'(k), fr.data, MASK_BOTH, 1'b0, k == 5);
            end else begin
               blit_row_writes(req_data);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_writes.size() == 0) begin
               report_mismatch($sformatf("unexpected write %h/%h/%b/%b/%b",
                  rsp_data.byte_addr, rsp_data.byte_data, rsp_data.nibble_mask,
                  rsp_data.combine_or, rsp_data.last));
            end else begin
               want = pending_writes.pop_front();
               if (rsp_data.byte_addr !== want.byte_addr
                   || rsp_data.byte_data !== want.byte_data
                   || rsp_data.nibble_mask !== want.nibble_mask
                   || rsp_data.combine_or !== want.combine_or
                   || rsp_data.last !== want.last)
                  report_mismatch($sformatf("write %h/%h/%b/%b/%b expected %h/%h/%b/%b/%b",
                     rsp_data.byte_addr, rsp_data.byte_data, rsp_data.nibble_mask,
                     rsp_data.combine_or, rsp_data.last, want.byte_addr, want.byte_data,
                     want.nibble_mask, want.combine_or, want.last));
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** glyph_row_nibble_blit: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         case (directed_steps[i].kind)
            STEP_CSR: begin
               drain();
               csr_write(directed_steps[i].csr_idx, directed_steps[i].csr_val);
            end
            STEP_FIXED: send_row(directed_steps[i].rq, 1'b1, directed_steps[i].addr0,
                                 directed_steps[i].data);
            STEP_ROW: send_row(directed_steps[i].rq, 1'b0, '0, '0);
            default: ;
         endcase
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct  = (phase == 0) ? 29 : (phase == 1) ? 51 : 0;
         stall_pct = (phase == 0) ? 51 : (phase == 1) ? 29 : 0;
         for (int blk = 0; blk < 3; blk++) begin
            drain();
            random_config();
            // back up the output while rows keep coming
            if (phase == 2 && blk == 0)
               hold_armed = 1'b1;
            repeat (ROWS_PER_CFG) send_row(random_row(), 1'b0, '0, '0);
         end
      end

      drain();
      if (mismatches == 0)
         $display("** glyph_row_nibble_blit: PASSED **");
      else
         $display("** glyph_row_nibble_blit: FAILED **");
      $finish;
   end

endmodule
